// ===== hw/rtl/rmst_pkg.sv =====
package rmst_pkg;

   localparam int LEAF_COUNT = 1024;
   localparam int NODE_COUNT = 2 * LEAF_COUNT;
   localparam int NODE_BITS  = $clog2(NODE_COUNT);
   localparam int WALK_BITS  = $clog2(NODE_COUNT + 1);
   localparam int INDEX_BITS = 10;
   localparam int VALUE_BITS = 30;

   localparam logic [VALUE_BITS-1:0] SENTINEL = 30'h3f3f3f3f;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      op_type                  operation;
      logic [INDEX_BITS-1:0]   leaf_index;
      logic [VALUE_BITS-1:0]   leaf_value;
      logic [INDEX_BITS-1:0]   range_low;
      logic [INDEX_BITS-1:0]   range_high;
   } cmd_type;

   typedef struct packed {
      logic                    idle;
      logic                    done;
      logic [VALUE_BITS-1:0]   minimum;
   } status_type;

endpackage

// ===== hw/rtl/rmst_if.sv =====
interface rmst_req_if import rmst_pkg::*; ();
   logic                  valid;
   logic                  ready;
   op_type                operation;
   logic [INDEX_BITS-1:0] leaf_index;
   logic [VALUE_BITS-1:0] leaf_value;
   logic [INDEX_BITS-1:0] range_low;
   logic [INDEX_BITS-1:0] range_high;

   modport source (
      output valid, operation, leaf_index, leaf_value, range_low, range_high,
      input  ready
   );
   modport sink (
      input  valid, operation, leaf_index, leaf_value, range_low, range_high,
      output ready
   );
endinterface

interface rmst_rsp_if import rmst_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] range_minimum;

   modport source (
      output valid, range_minimum,
      input  ready
   );
   modport sink (
      input  valid, range_minimum,
      output ready
   );
endinterface

// ===== hw/rtl/rmst_min_unit.sv =====
module rmst_min_unit import rmst_pkg::*; (
   input  logic [VALUE_BITS-1:0] a,
   input  logic [VALUE_BITS-1:0] b,
   output logic [VALUE_BITS-1:0] y
);

   assign y = (a < b) ? a : b;

endmodule

// ===== hw/rtl/rmst_walker.sv =====
module rmst_walker import rmst_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  cmd_type    cmd,
   input  logic       ack,
   output status_type status
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_WR_UP,
      S_Q_LEFT,
      S_Q_RIGHT,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [WALK_BITS-1:0]  node_ff, node_in;
   logic [WALK_BITS-1:0]  right_ff, right_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  pend_ff, pend_in;
   logic [NODE_BITS-1:0]  clr_ff, clr_in;
   logic [VALUE_BITS-1:0] rd_data_ff;

   logic [VALUE_BITS-1:0] node_mem [NODE_COUNT];

   logic                  wr_en;
   logic [NODE_BITS-1:0]  wr_addr;
   logic [VALUE_BITS-1:0] wr_data;
   logic                  rd_en;
   logic [NODE_BITS-1:0]  rd_addr;

   logic [VALUE_BITS-1:0] min_y;
   logic                  leaf_ok;
   logic [NODE_BITS-1:0]  leaf_node;
   logic [VALUE_BITS-1:0] sat_value;
   logic [31:0]           high_clamp;
   logic                  range_empty;
   logic [WALK_BITS-1:0]  left_start;
   logic [WALK_BITS-1:0]  right_start;
   logic [WALK_BITS-1:0]  parent;
   logic [WALK_BITS-1:0]  right_dec;

   // shared compare unit: accumulator against the word read last cycle
   rmst_min_unit u_min (
      .a (acc_ff),
      .b (rd_data_ff),
      .y (min_y)
   );

   assign leaf_ok     = 32'(cmd.leaf_index) < LEAF_COUNT;
   assign leaf_node   = NODE_BITS'(32'(LEAF_COUNT) + 32'(cmd.leaf_index));
   assign sat_value   = (cmd.leaf_value > SENTINEL) ? SENTINEL : cmd.leaf_value;
   assign high_clamp  = (32'(cmd.range_high) >= LEAF_COUNT) ? 32'(LEAF_COUNT - 1)
                                                           : 32'(cmd.range_high);
   assign range_empty = 32'(cmd.range_low) > high_clamp;
   assign left_start  = WALK_BITS'(32'(LEAF_COUNT) + 32'(cmd.range_low));
   assign right_start = WALK_BITS'(32'(LEAF_COUNT) + high_clamp + 32'd1);
   assign parent      = node_ff >> 1;
   assign right_dec   = right_ff - WALK_BITS'(1);

   always_comb begin
      state_in = state_ff;
      node_in  = node_ff;
      right_in = right_ff;
      acc_in   = acc_ff;
      pend_in  = 1'b0;
      clr_in   = clr_ff;
      wr_en    = 1'b0;
      wr_addr  = clr_ff;
      wr_data  = SENTINEL;
      rd_en    = 1'b0;
      rd_addr  = node_ff[NODE_BITS-1:0];
      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = SENTINEL;
            clr_in  = clr_ff + NODE_BITS'(1);
            if (clr_ff == NODE_BITS'(NODE_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               if (cmd.operation == OP_WRITE) begin
                  if (leaf_ok) begin
                     wr_en    = 1'b1;
                     wr_addr  = leaf_node;
                     wr_data  = sat_value;
                     rd_en    = 1'b1;
                     rd_addr  = leaf_node ^ NODE_BITS'(1);
                     node_in  = WALK_BITS'(leaf_node);
                     acc_in   = sat_value;
                     state_in = S_WR_UP;
                  end
               end else begin
                  acc_in = SENTINEL;
                  if (range_empty) begin
                     state_in = S_DONE;
                  end else begin
                     node_in  = left_start;
                     right_in = right_start;
                     state_in = S_Q_LEFT;
                  end
               end
            end
         end
         S_WR_UP: begin
            // parent takes min of the carried value and its sibling
            acc_in  = min_y;
            wr_en   = 1'b1;
            wr_addr = parent[NODE_BITS-1:0];
            wr_data = min_y;
            node_in = parent;
            if (parent > WALK_BITS'(1)) begin
               rd_en   = 1'b1;
               rd_addr = parent[NODE_BITS-1:0] ^ NODE_BITS'(1);
            end else begin
               state_in = S_IDLE;
            end
         end
         S_Q_LEFT: begin
            if (pend_ff) begin
               acc_in = min_y;
            end
            if (node_ff >= right_ff) begin
               state_in = S_DONE;
            end else begin
               if (node_ff[0]) begin
                  rd_en   = 1'b1;
                  rd_addr = node_ff[NODE_BITS-1:0];
                  pend_in = 1'b1;
                  node_in = node_ff + WALK_BITS'(1);
               end
               state_in = S_Q_RIGHT;
            end
         end
         S_Q_RIGHT: begin
            if (pend_ff) begin
               acc_in = min_y;
            end
            if (right_ff[0]) begin
               rd_en    = 1'b1;
               rd_addr  = right_dec[NODE_BITS-1:0];
               pend_in  = 1'b1;
               right_in = right_dec >> 1;
            end else begin
               right_in = right_ff >> 1;
            end
            node_in  = node_ff >> 1;
            state_in = S_Q_LEFT;
         end
         S_DONE: begin
            if (ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      node_ff  <= node_in;
      right_ff <= right_in;
      acc_ff   <= acc_in;
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= node_mem[rd_addr];
      end
   end

   assign status.idle    = (state_ff == S_IDLE);
   assign status.done    = (state_ff == S_DONE);
   assign status.minimum = acc_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == S_IDLE)
      else $error("item started while walker busy");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (status.done && !ack) |=> (status.done && $stable(acc_ff)))
      else $error("result dropped or changed before transfer");

   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> state_ff == S_CLEAR)
      else $error("clearing pass not restarted by reset");

   a_no_node0_write: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff != S_CLEAR) |-> wr_addr != '0)
      else $error("tree update wrote unused node");

   a_walk_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_Q_RIGHT) |-> node_ff <= right_ff)
      else $error("query walk bounds crossed");

endmodule

// ===== hw/rtl/range_minimum_segment_tree_unit.sv =====
// write: 1 cycle at the leaf, then 1 cycle per tree level (11 cycles for 1024 leaves)
// query: 2 cycles per level plus 1 to finish and 1 to the output register (up to 25 cycles)
// one item at a time, set by the node memory walk and the shared min unit
// a waiting result sits in the output register while the next item is taken
// after reset the node memory is cleared, one node a cycle: 2048 cycles before req_bus.ready
module range_minimum_segment_tree_unit import rmst_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rmst_req_if.sink  req_bus,
   rmst_rsp_if.source rsp_bus
);

   cmd_type               cmd;
   status_type            status;
   logic                  start;
   logic                  load;
   logic                  rsp_valid_ff;
   logic [VALUE_BITS-1:0] rsp_minimum_ff;

   assign cmd.operation  = req_bus.operation;
   assign cmd.leaf_index = req_bus.leaf_index;
   assign cmd.leaf_value = req_bus.leaf_value;
   assign cmd.range_low  = req_bus.range_low;
   assign cmd.range_high = req_bus.range_high;

   assign req_bus.ready = status.idle;
   assign start         = req_bus.valid && req_bus.ready;

   rmst_walker u_walker (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .cmd    (cmd),
      .ack    (load),
      .status (status)
   );

   // output register frees the walker once a result is parked
   assign load = status.done && (!rsp_valid_ff || rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_minimum_ff <= status.minimum;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.range_minimum = rsp_minimum_ff;

endmodule
